// ----- src/mtr_pkg.sv -----
`timescale 1ns / 1ps

package mtr_pkg;

    // Size of the generator state.
    localparam int STATE_WORDS = 624;
    localparam int ADDR_W      = $clog2(STATE_WORDS);
    localparam int WORD_W      = 32;
    localparam int TWIST_OFFSET = 397;

    // Recurrence and tempering constants.
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

    // One write into the state memory.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } mem_wr_t;

    // Output tempering of one state word.
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ----- src/mtr_ram.sv -----
`timescale 1ns / 1ps

module mtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr0,
    output logic [WIDTH-1:0]         rd_data0,
    input  logic [$clog2(DEPTH)-1:0] rd_addr1,
    output logic [WIDTH-1:0]         rd_data1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data0 <= mem[rd_addr0];
        rd_data1 <= mem[rd_addr1];
    end

endmodule

// ----- src/mtr_seeder.sv -----
`timescale 1ns / 1ps

module mtr_seeder
    import mtr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] seed,
    output mem_wr_t           wr,
    output logic              done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD
    } seed_state_t;

    seed_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [WORD_W-1:0] prev_reg, prev_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] sum;

    // One recurrence step: multiply, register, then add the index.
    assign mix = prev_reg ^ (prev_reg >> 30);
    assign sum = prod_reg + WORD_W'(idx_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        prod_next  = prod_reg;
        wr         = '0;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = '0;
                    wr.data    = seed;
                    prev_next  = seed;
                    idx_next   = ADDR_W'(1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = SEED_MULT * mix;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                wr.en     = 1'b1;
                wr.addr   = idx_reg;
                wr.data   = sum;
                prev_next = sum;
                if (idx_reg == ADDR_W'(STATE_WORDS - 1))
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        prod_reg <= prod_next;
    end

endmodule

// ----- src/mersenne_twister_rng_unit.sv -----
`timescale 1ns / 1ps

// MT19937 random word generator.
// Request channel s_axis: each word carries one flag, restart, in tdata bit 0.
// A request with restart set first reseeds all 624 state words from the seed
// register; the word then comes from the freshly twisted state.
// Result channel m_axis: one tempered 32-bit word per request.
// Configuration channel cfg: writes the seed register (reset value 5489). A
// write is stored only and is used by the next restart.
// Each state word is twisted in place when it is read: the word and its
// successor are read, then the far word, and the twisted word is written back
// as the result is registered. A new request is taken only once the previous
// result is in the output register. A reseed walks the memory with a
// multiply-add step per word (S_MUL, S_ADD) before the request continues.
// After reset the block runs the same seeding pass from 5489 with
// s_axis_tready low; configuration writes are taken throughout.
// The result is held in an output register; if the receiver stalls, the
// block finishes the next word's reads and then waits until the register
// is taken before writing back.
module mersenne_twister_rng_unit
    import mtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] random_word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_START,
        S_SEED_WAIT,
        S_READ,
        S_MIX,
        S_TWIST
    } ctl_state_t;

    ctl_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              pending_reg, pending_next;
    logic [WORD_W-1:0] y_reg, y_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic [WORD_W-1:0] seed_reg;

    logic [ADDR_W-1:0] idx_succ;
    logic [ADDR_W-1:0] idx_far;
    logic [ADDR_W-1:0] rd_addr0;
    logic [ADDR_W-1:0] rd_addr1;
    logic [WORD_W-1:0] rd_data0;
    logic [WORD_W-1:0] rd_data1;
    logic [WORD_W-1:0] twisted;
    logic              seed_start;
    logic              seed_done;
    mem_wr_t           seed_wr;
    mem_wr_t           twist_wr;
    mem_wr_t           mem_wr;
    logic              in_acc;
    logic              out_free;

    // Seed register; the port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_valid)
        begin
            seed_reg <= cfg_data;
        end
    end

    // Neighbor addresses of the current word, wrapping around the ring.
    assign idx_succ = (idx_reg == ADDR_W'(STATE_WORDS - 1)) ? '0 : idx_reg + ADDR_W'(1);
    assign idx_far  = (idx_reg < ADDR_W'(STATE_WORDS - TWIST_OFFSET))
                    ? idx_reg + ADDR_W'(TWIST_OFFSET)
                    : idx_reg - ADDR_W'(STATE_WORDS - TWIST_OFFSET);

    // The far word is read once the pair has been read; the address holds
    // during a stall so the read data stays valid.
    assign rd_addr0 = (state_reg == S_MIX || state_reg == S_TWIST) ? idx_far : idx_reg;
    assign rd_addr1 = idx_succ;

    // Twist recurrence for the current word.
    assign twisted = rd_data0 ^ (y_reg >> 1) ^ (y_reg[0] ? TWIST_MATRIX : '0);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign seed_start    = (state_reg == S_SEED_START);

    assign twist_wr.en   = (state_reg == S_TWIST) && out_free;
    assign twist_wr.addr = idx_reg;
    assign twist_wr.data = twisted;
    assign mem_wr        = seed_wr.en ? seed_wr : twist_wr;

    // Control sequencer.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pending_next   = pending_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tdata[0])
                    begin
                        pending_next = 1'b1;
                        state_next   = S_SEED_START;
                    end
                    else
                    begin
                        state_next = S_MIX;
                    end
                end
            end
            S_SEED_START:
            begin
                state_next = S_SEED_WAIT;
            end
            S_SEED_WAIT:
            begin
                if (seed_done)
                begin
                    idx_next     = '0;
                    pending_next = 1'b0;
                    state_next   = pending_reg ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_MIX;
            end
            S_MIX:
            begin
                y_next     = (rd_data0 & HIGH_BIT) | (rd_data1 & LOW_BITS);
                state_next = S_TWIST;
            end
            S_TWIST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = temper(twisted);
                    idx_next       = idx_succ;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SEED_START;
            idx_reg       <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg        <= y_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    mtr_seeder u_seeder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_start),
        .seed  (seed_reg),
        .wr    (seed_wr),
        .done  (seed_done)
    );

    mtr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .clk      (clk),
        .wr_en    (mem_wr.en),
        .wr_addr  (mem_wr.addr),
        .wr_data  (mem_wr.data),
        .rd_addr0 (rd_addr0),
        .rd_data0 (rd_data0),
        .rd_addr1 (rd_addr1),
        .rd_data1 (rd_data1)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench
    import mtr_pkg::*;
();

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] random_word
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data      = 32'd0;

    // Requests waiting to be sent (restart flag) and words still owed by the block.
    bit          pending_requests[$];
    logic [31:0] expected_words[$];

    // Generator model: state array, read position and seed register.
    logic [31:0] mt_state [0:STATE_WORDS-1];
    int unsigned mt_pos;
    logic [31:0] seed_reg;

    int send_idle_pct = 10;
    int recv_idle_pct = 51;
    int words_checked = 0;
    int mismatches    = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    mersenne_twister_rng_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Fill the state array from a seed with the 1812433253 recurrence.
    function automatic void reseed_state(input logic [31:0] s);
        logic [31:0] p;
        mt_state[0] = s;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            p = mt_state[i-1];
            mt_state[i] = SEED_MULT * (p ^ (p >> 30)) + 32'(i);
        end
        mt_pos = STATE_WORDS;
    endfunction

    // Twist every state word in place, in index order.
    function automatic void regenerate_state();
        logic [31:0] y;
        logic [31:0] v;
        for (int k = 0; k < STATE_WORDS; k++)
        begin
            y = (mt_state[k] & HIGH_BIT) | (mt_state[(k + 1) % STATE_WORDS] & LOW_BITS);
            v = mt_state[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0])
                v = v ^ TWIST_MATRIX;
            mt_state[k] = v;
        end
        mt_pos = 0;
    endfunction

    // Advance the model by one request and return the tempered word.
    function automatic logic [31:0] next_word(input logic restart);
        logic [31:0] y;
        if (restart)
            reseed_state(seed_reg);
        if (mt_pos >= STATE_WORDS)
            regenerate_state();
        y = mt_state[mt_pos];
        mt_pos = mt_pos + 1;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Append one request to the end of the send queue.
    function automatic void add_request(input bit restart);
        pending_requests = {pending_requests, restart};
    endfunction

    // Write the seed register; only called while no request is in flight.
    task automatic write_seed(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        seed_reg = value;
    endtask

    // Wait until every request has been sent and every word has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_words.size() != 0);
    endtask

    // Queue a run of requests; restart_odds of 0 means no random restarts.
    task automatic queue_run(input int count, input int restart_odds, input bit first_restart);
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            if (i == 0 && first_restart)
                add_request(1'b1);
            else if (restart_odds != 0)
                add_request($urandom_range(restart_odds - 1) == 0);
            else
                add_request(1'b0);
        end
    endtask

    // Request driver; the model is stepped on every accepted word.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_words = {expected_words, next_word(s_axis_tdata[0])};
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_requests.size() != 0 && int'($urandom_range(99)) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, pending_requests.pop_front()};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver, with one long hold-off once 60 words have been checked.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && words_checked >= 60)
        begin
            hold_done     <= 1'b1;
            hold_left     <= 300;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= int'($urandom_range(99)) >= recv_idle_pct;
        end
    end

    // Result monitor: each word is compared with the oldest prediction.
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected word %h at %0t", m_axis_tdata, $realtime);
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_axis_tdata !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Word %0d mismatch: random_word expected %h, got %h",
                                 words_checked, want, m_axis_tdata);
                end
            end
            words_checked <= words_checked + 1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        seed_reg = SEED_RESET;
        reseed_state(SEED_RESET);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Words straight from the reset seeding.
        queue_run(3, 0, 1'b0);
        wait_drained();

        // Restart from the all-zero seed.
        write_seed(32'h0000_0000);
        queue_run(3, 0, 1'b1);
        wait_drained();

        // All-ones seed, with three restarts, two of them back to back.
        write_seed(32'hffff_ffff);
        @(negedge clk);
        add_request(1'b1);
        add_request(1'b0);
        add_request(1'b1);
        add_request(1'b1);
        add_request(1'b0);
        wait_drained();

        // A seed write alone must leave the state alone until the next restart.
        write_seed(32'h1234_5678);
        @(negedge clk);
        add_request(1'b0);
        add_request(1'b0);
        add_request(1'b1);
        add_request(1'b0);
        wait_drained();

        // New random seed; sender idling lightly and receiver heavily.
        write_seed($urandom);
        queue_run(320, 0, 1'b1);
        wait_drained();

        // Sender idles heavily, receiver lightly; no restarts, so the two runs
        // together pass the second twist of the state.
        send_idle_pct = 51;
        recv_idle_pct = 10;
        queue_run(310, 0, 1'b0);
        wait_drained();

        // No idling, another random seed and frequent random restarts.
        write_seed($urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_run(20, 4, 1'b1);
        wait_drained();

        repeat (20) @(negedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/mtr_pkg.sv
src/mtr_ram.sv
src/mtr_seeder.sv
src/mersenne_twister_rng_unit.sv
tb/testbench.sv
